// ===== rtl/kos_pkg.sv =====
// Shared types, constants and the arctangent table of the kinematic object step unit.
`timescale 1ns / 1ps
package kos_pkg;

   // Command codes carried by a request beat.
   localparam logic [1:0] CMD_STEP     = 2'd0;
   localparam logic [1:0] CMD_LOAD_VEL = 2'd1;
   localparam logic [1:0] CMD_LOAD_POS = 2'd2;

   // Configuration register indexes.
   localparam logic [1:0] CSR_MAX_SPEED    = 2'd0;
   localparam logic [1:0] CSR_USE_GRAVITY  = 2'd1;
   localparam logic [1:0] CSR_GRAVITY_STEP = 2'd2;
   localparam logic [1:0] CSR_FRICTION     = 2'd3;

   // Number of CORDIC vectoring steps, at most 24.
   localparam int unsigned CORDIC_ITERATIONS = 16;

   // Ninety degrees in Q16 and the heading clamp limits in Q9.7.
   localparam logic signed [27:0] DEG90_Q16   = 28'sd5898240;
   localparam logic signed [27:0] HEADING_MAX = 28'sd11520;
   localparam logic signed [27:0] HEADING_MIN = -28'sd34560;

   // Sequencer states.
   typedef enum logic [4:0] {
      ST_IDLE,
      ST_SQ_MUL,
      ST_SQ_ACC,
      ST_LIM_MUL,
      ST_LIM_CMP,
      ST_SQRT,
      ST_DIV_MUL,
      ST_DIV_LOAD,
      ST_DIV,
      ST_DIV_WB,
      ST_ADV_MUL,
      ST_ADV_ACC,
      ST_GRAV,
      ST_HEAD_CHK,
      ST_CORDIC,
      ST_YAW,
      ST_FRIC_MUL,
      ST_FRIC_WB,
      ST_DONE
   } state_type;

   // atan(2^-i) in Q16 degrees.
   function automatic logic [21:0] atan_q16(input logic [4:0] i);
      logic [21:0] r;
      unique case (i)
         5'd0:  r = 22'd2949120;
         5'd1:  r = 22'd1740967;
         5'd2:  r = 22'd919879;
         5'd3:  r = 22'd466945;
         5'd4:  r = 22'd234379;
         5'd5:  r = 22'd117304;
         5'd6:  r = 22'd58666;
         5'd7:  r = 22'd29335;
         5'd8:  r = 22'd14668;
         5'd9:  r = 22'd7334;
         5'd10: r = 22'd3667;
         5'd11: r = 22'd1833;
         5'd12: r = 22'd917;
         5'd13: r = 22'd458;
         5'd14: r = 22'd229;
         5'd15: r = 22'd115;
         5'd16: r = 22'd57;
         5'd17: r = 22'd29;
         5'd18: r = 22'd14;
         5'd19: r = 22'd7;
         5'd20: r = 22'd4;
         5'd21: r = 22'd2;
         5'd22: r = 22'd1;
         default: r = 22'd0;
      endcase
      return r;
   endfunction

endpackage

// ===== rtl/kinematic_object_step_unit.sv =====
// Top level of the kinematic object step unit: sequencer around one shared multiplier.
`timescale 1ns / 1ps
// Keeps one object's position, velocity and heading and returns the full state after
// every request beat. A load's result beat is valid in the cycle after its request
// beat is taken. A step runs on one shared 33x33 multiplier and a one-bit-per-cycle
// add/subtract unit under a sequencer. The heading is updated only when the speed
// exceeds 1.0, by the heading CORDIC unless the horizontal velocity is zero. A velocity
// that must be clamped first passes the square root and three divisions, one per
// component. One request is in flight at a time: the next request beat is taken only
// after the result beat has been taken.
module kinematic_object_step_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_cmd,
   input  logic [15:0]        req_dt,
   input  logic signed [31:0] req_value_x,
   input  logic signed [31:0] req_value_y,
   input  logic signed [31:0] req_value_z,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_pos_x,
   output logic signed [31:0] rsp_pos_y,
   output logic signed [31:0] rsp_pos_z,
   output logic signed [31:0] rsp_vel_x,
   output logic signed [31:0] rsp_vel_y,
   output logic signed [31:0] rsp_vel_z,
   output logic signed [16:0] rsp_heading,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [31:0]        csr_wdata
);
   import kos_pkg::*;

   state_type          state_ff, state_in;
   logic [1:0]         idx_ff, idx_in;
   logic [4:0]         iter_ff, iter_in;
   logic               pass2_ff, pass2_in;
   logic [15:0]        dt_ff, dt_in;
   logic [31:0]        pos_ff [3];
   logic [31:0]        pos_in [3];
   logic signed [31:0] vel_ff [3];
   logic signed [31:0] vel_in [3];
   logic signed [16:0] yaw_ff, yaw_in;
   logic [30:0]        max_speed_ff;
   logic               use_gravity_ff;
   logic [30:0]        gravity_step_ff;
   logic [16:0]        friction_ff;
   logic signed [63:0] prod_ff, prod_in;
   logic [63:0]        sq_ff, sq_in;
   logic [63:0]        rad_ff, rad_in;
   logic [31:0]        root_ff, root_in;
   logic [33:0]        srem_ff, srem_in;
   logic [31:0]        dvd_ff, dvd_in;
   logic [32:0]        drem_ff, drem_in;
   logic [31:0]        quo_ff, quo_in;
   logic               neg_ff, neg_in;
   logic signed [34:0] cx_ff, cx_in, cy_ff, cy_in;
   logic signed [27:0] acc_ff, acc_in;

   logic signed [32:0] mul_a, mul_b;
   logic signed [65:0] mul_p;
   logic signed [32:0] vcur, vabs;
   logic [33:0]        rem_sh, trial;
   logic [32:0]        dtry;
   logic signed [34:0] xs, ys, vx35, vz35;
   logic signed [27:0] ang;
   logic signed [27:0] hdg;
   logic signed [47:0] fs;

   // Shared multiplier.
   assign mul_p = mul_a * mul_b;

   assign vcur = {vel_ff[idx_ff][31], vel_ff[idx_ff]};
   assign vabs = vcur[32] ? -vcur : vcur;
   assign rem_sh = {srem_ff[31:0], rad_ff[63:62]};
   assign trial  = {root_ff, 2'b01};
   assign dtry   = {drem_ff[31:0], dvd_ff[31]};
   assign xs = cx_ff >>> iter_ff;
   assign ys = cy_ff >>> iter_ff;
   assign vx35 = {{3{vel_ff[0][31]}}, vel_ff[0]};
   assign vz35 = {{3{vel_ff[2][31]}}, vel_ff[2]};
   assign ang = acc_ff - DEG90_Q16 + 28'sd256;
   assign hdg = ang >>> 9;
   assign fs  = prod_ff[63:16];

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_DONE);
   assign csr_ready = 1'b1;
   assign rsp_pos_x = pos_ff[0];
   assign rsp_pos_y = pos_ff[1];
   assign rsp_pos_z = pos_ff[2];
   assign rsp_vel_x = vel_ff[0];
   assign rsp_vel_y = vel_ff[1];
   assign rsp_vel_z = vel_ff[2];
   assign rsp_heading = yaw_ff;

   // State and architectural registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff <= 2'd0;
         iter_ff <= 5'd0;
         pass2_ff <= 1'b0;
         for (int i = 0; i < 3; i++) begin
            pos_ff[i] <= 32'd0;
            vel_ff[i] <= 32'sd0;
         end
         yaw_ff <= 17'sd0;
      end else begin
         state_ff <= state_in;
         idx_ff <= idx_in;
         iter_ff <= iter_in;
         pass2_ff <= pass2_in;
         pos_ff <= pos_in;
         vel_ff <= vel_in;
         yaw_ff <= yaw_in;
      end
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         max_speed_ff <= 31'd655360;
         use_gravity_ff <= 1'b0;
         gravity_step_ff <= 31'd0;
         friction_ff <= 17'd65536;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_MAX_SPEED:    max_speed_ff <= csr_wdata[30:0];
            CSR_USE_GRAVITY:  use_gravity_ff <= csr_wdata[0];
            CSR_GRAVITY_STEP: gravity_step_ff <= csr_wdata[30:0];
            CSR_FRICTION:     friction_ff <= csr_wdata[16:0];
            default: ;
         endcase
      end
   end

   // Working registers of the arithmetic units.
   always_ff @(posedge clock) begin
      dt_ff <= dt_in;
      prod_ff <= prod_in;
      sq_ff <= sq_in;
      rad_ff <= rad_in;
      root_ff <= root_in;
      srem_ff <= srem_in;
      dvd_ff <= dvd_in;
      drem_ff <= drem_in;
      quo_ff <= quo_in;
      neg_ff <= neg_in;
      cx_ff <= cx_in;
      cy_ff <= cy_in;
      acc_ff <= acc_in;
   end

   // Sequencer: next state and datapath updates.
   always_comb begin
      state_in = state_ff;
      idx_in = idx_ff;
      iter_in = iter_ff;
      pass2_in = pass2_ff;
      dt_in = dt_ff;
      pos_in = pos_ff;
      vel_in = vel_ff;
      yaw_in = yaw_ff;
      prod_in = prod_ff;
      sq_in = sq_ff;
      rad_in = rad_ff;
      root_in = root_ff;
      srem_in = srem_ff;
      dvd_in = dvd_ff;
      drem_in = drem_ff;
      quo_in = quo_ff;
      neg_in = neg_ff;
      cx_in = cx_ff;
      cy_in = cy_ff;
      acc_in = acc_ff;
      mul_a = vcur;
      mul_b = vcur;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && !req_stall) begin
               unique case (req_cmd)
                  CMD_STEP: begin
                     dt_in = req_dt;
                     sq_in = 64'd0;
                     idx_in = 2'd0;
                     pass2_in = 1'b0;
                     state_in = ST_SQ_MUL;
                  end
                  CMD_LOAD_VEL: begin
                     vel_in[0] = req_value_x;
                     vel_in[1] = req_value_y;
                     vel_in[2] = req_value_z;
                     state_in = ST_DONE;
                  end
                  CMD_LOAD_POS: begin
                     pos_in[0] = req_value_x;
                     pos_in[1] = req_value_y;
                     pos_in[2] = req_value_z;
                     state_in = ST_DONE;
                  end
                  default: state_in = ST_DONE;
               endcase
            end
         end
         // Squared length, one component at a time: multiply, then accumulate.
         ST_SQ_MUL: begin
            prod_in = mul_p[63:0];
            state_in = ST_SQ_ACC;
         end
         ST_SQ_ACC: begin
            sq_in = sq_ff + $unsigned(prod_ff);
            if (idx_ff == 2'd2) begin
               idx_in = 2'd0;
               state_in = pass2_ff ? ST_HEAD_CHK : ST_LIM_MUL;
            end else begin
               idx_in = idx_ff + 2'd1;
               state_in = ST_SQ_MUL;
            end
         end
         ST_LIM_MUL: begin
            mul_a = {2'b00, max_speed_ff};
            mul_b = {2'b00, max_speed_ff};
            prod_in = mul_p[63:0];
            state_in = ST_LIM_CMP;
         end
         ST_LIM_CMP: begin
            rad_in = sq_ff;
            root_in = 32'd0;
            srem_in = 34'd0;
            iter_in = 5'd0;
            idx_in = 2'd0;
            state_in = (sq_ff > $unsigned(prod_ff)) ? ST_SQRT : ST_ADV_MUL;
         end
         // Square root, one result bit per cycle.
         ST_SQRT: begin
            if (rem_sh >= trial) begin
               srem_in = rem_sh - trial;
               root_in = {root_ff[30:0], 1'b1};
            end else begin
               srem_in = rem_sh;
               root_in = {root_ff[30:0], 1'b0};
            end
            rad_in = {rad_ff[61:0], 2'b00};
            iter_in = iter_ff + 5'd1;
            if (iter_ff == 5'd31) state_in = ST_DIV_MUL;
         end
         // Clamp: |v| * max_speed / length per component.
         ST_DIV_MUL: begin
            mul_a = vabs;
            mul_b = {2'b00, max_speed_ff};
            prod_in = mul_p[63:0];
            neg_in = vcur[32];
            state_in = ST_DIV_LOAD;
         end
         ST_DIV_LOAD: begin
            drem_in = {1'b0, prod_ff[63:32]};
            dvd_in = prod_ff[31:0];
            quo_in = 32'd0;
            iter_in = 5'd0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (dtry >= {1'b0, root_ff}) begin
               drem_in = dtry - {1'b0, root_ff};
               quo_in = {quo_ff[30:0], 1'b1};
            end else begin
               drem_in = dtry;
               quo_in = {quo_ff[30:0], 1'b0};
            end
            dvd_in = {dvd_ff[30:0], 1'b0};
            iter_in = iter_ff + 5'd1;
            if (iter_ff == 5'd31) state_in = ST_DIV_WB;
         end
         ST_DIV_WB: begin
            vel_in[idx_ff] = neg_ff ? -quo_ff : quo_ff;
            if (idx_ff == 2'd2) begin
               idx_in = 2'd0;
               state_in = ST_ADV_MUL;
            end else begin
               idx_in = idx_ff + 2'd1;
               state_in = ST_DIV_MUL;
            end
         end
         // Position advance by v * dt, floored to Q16.16.
         ST_ADV_MUL: begin
            mul_b = {17'd0, dt_ff};
            prod_in = mul_p[63:0];
            state_in = ST_ADV_ACC;
         end
         ST_ADV_ACC: begin
            pos_in[idx_ff] = pos_ff[idx_ff] + prod_ff[47:16];
            if (idx_ff == 2'd2) begin
               idx_in = 2'd0;
               state_in = ST_GRAV;
            end else begin
               idx_in = idx_ff + 2'd1;
               state_in = ST_ADV_MUL;
            end
         end
         ST_GRAV: begin
            if (use_gravity_ff) pos_in[1] = pos_ff[1] - {1'b0, gravity_step_ff};
            sq_in = 64'd0;
            pass2_in = 1'b1;
            idx_in = 2'd0;
            state_in = ST_SQ_MUL;
         end
         // Heading only when the speed exceeds 1.0.
         ST_HEAD_CHK: begin
            iter_in = 5'd0;
            idx_in = 2'd0;
            cx_in = vx35;
            cy_in = vz35;
            acc_in = 28'sd0;
            if (vx35 < 0) begin
               if (vz35 >= 0) begin
                  cx_in = vz35;
                  cy_in = -vx35;
                  acc_in = DEG90_Q16;
               end else begin
                  cx_in = -vz35;
                  cy_in = vx35;
                  acc_in = -DEG90_Q16;
               end
            end
            if (sq_ff <= 64'h1_0000_0000) begin
               state_in = ST_FRIC_MUL;
            end else if (vx35 == 0 && vz35 == 0) begin
               acc_in = 28'sd0;
               state_in = ST_YAW;
            end else begin
               state_in = ST_CORDIC;
            end
         end
         ST_CORDIC: begin
            if (cy_ff > 0) begin
               cx_in = cx_ff + ys;
               cy_in = cy_ff - xs;
               acc_in = acc_ff + $signed({6'd0, atan_q16(iter_ff)});
            end else begin
               cx_in = cx_ff - ys;
               cy_in = cy_ff + xs;
               acc_in = acc_ff - $signed({6'd0, atan_q16(iter_ff)});
            end
            iter_in = iter_ff + 5'd1;
            if (iter_ff == 5'(CORDIC_ITERATIONS - 1)) state_in = ST_YAW;
         end
         ST_YAW: begin
            if (hdg > HEADING_MAX) yaw_in = HEADING_MAX[16:0];
            else if (hdg < HEADING_MIN) yaw_in = HEADING_MIN[16:0];
            else yaw_in = hdg[16:0];
            idx_in = 2'd0;
            state_in = ST_FRIC_MUL;
         end
         // Friction with saturation to the 32-bit range.
         ST_FRIC_MUL: begin
            mul_b = {16'd0, friction_ff};
            prod_in = mul_p[63:0];
            state_in = ST_FRIC_WB;
         end
         ST_FRIC_WB: begin
            if (!fs[47] && (|fs[46:31])) vel_in[idx_ff] = 32'sh7fff_ffff;
            else if (fs[47] && !(&fs[46:31])) vel_in[idx_ff] = 32'sh8000_0000;
            else vel_in[idx_ff] = fs[31:0];
            if (idx_ff == 2'd2) begin
               idx_in = 2'd0;
               state_in = ST_DONE;
            end else begin
               idx_in = idx_ff + 2'd1;
               state_in = ST_FRIC_MUL;
            end
         end
         ST_DONE: begin
            if (!rsp_stall) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

// ===== rtl/kos_checker.sv =====
// Port-level assertions for the kinematic object step unit and their bind.
`timescale 1ns / 1ps
module kos_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic signed [31:0] rsp_pos_y,
   input logic signed [16:0] rsp_heading
);
   // A held result beat stays valid and keeps its y position.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_pos_y))
      else $error("result beat dropped or changed while stalled");

   // Once a request beat is taken, the block is busy the next cycle.
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request accepted while an item is in flight");

   // No request is taken while a result waits.
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("request accepted with a result pending");

   // Heading stays within its clamp range.
   a_heading: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_heading >= -17'sd34560) && (rsp_heading <= 17'sd11520))
      else $error("heading out of range");
endmodule

bind kinematic_object_step_unit kos_checker u_kos_checker (
   .clock(clock),
   .reset(reset),
   .req_valid(req_valid),
   .req_stall(req_stall),
   .rsp_valid(rsp_valid),
   .rsp_stall(rsp_stall),
   .rsp_pos_y(rsp_pos_y),
   .rsp_heading(rsp_heading)
);

// ===== tb/kinematic_object_step_unit_tb.sv =====
// Self-checking testbench of the kinematic object step unit with a built-in motion predictor.
`timescale 1ns / 1ps
module kinematic_object_step_unit_tb;
   import kos_pkg::*;

   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam int IDLE_PCT = 31;

   typedef struct packed {
      logic [31:0] pos_x, pos_y, pos_z;
      logic [31:0] vel_x, vel_y, vel_z;
      logic [16:0] heading;
   } object_state_t;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [1:0]         req_cmd = CMD_STEP;
   logic [15:0]        req_dt = '0;
   logic signed [31:0] req_value_x = '0, req_value_y = '0, req_value_z = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [31:0] rsp_pos_x, rsp_pos_y, rsp_pos_z;
   logic signed [31:0] rsp_vel_x, rsp_vel_y, rsp_vel_z;
   logic signed [16:0] rsp_heading;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [1:0]         csr_index = CSR_MAX_SPEED;
   logic [31:0]        csr_wdata = '0;

   kinematic_object_step_unit dut (.*);

   always #5 clock = ~clock;

   // Predicted object state and register copy.
   logic [31:0]        obj_pos [3];
   int                 obj_vel [3];
   logic signed [16:0] obj_yaw;
   longint             speed_limit, gravity_on, gravity_amount, friction;

   object_state_t expected_states [$];
   int  mismatches = 0;
   int  beats_sent = 0, results_seen = 0;
   bit  quiet = 1'b0;

   // atan(2^-i) in Q16 degrees.
   const longint atan_table [24] = '{2949120, 1740967, 919879, 466945, 234379, 117304,
      58666, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1, 0};

   function automatic longint unsigned speed_sq();
      longint unsigned s;
      s = 0;
      for (int i = 0; i < 3; i++) s += longint'(obj_vel[i]) * longint'(obj_vel[i]);
      return s;
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned n);
      longint unsigned r, b;
      r = 0;
      b = 64'h1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
         if (n >= r + b) begin
            n -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   // atan2(y, x) in Q16 degrees: quadrant fold, then vectoring rotations.
   function automatic longint atan2_deg(longint x, longint y);
      longint acc, t, xs, ys;
      acc = 0;
      if (x == 0 && y == 0) return 0;
      if (x < 0) begin
         t = x;
         if (y >= 0) begin
            x = y; y = -t; acc = 90 * 65536;
         end else begin
            x = -y; y = t; acc = -90 * 65536;
         end
      end
      for (int i = 0; i < CORDIC_ITERATIONS && i < 24; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y > 0) begin
            x += ys; y -= xs; acc += atan_table[i];
         end else begin
            x -= ys; y += xs; acc -= atan_table[i];
         end
      end
      return acc;
   endfunction

   // One physics step of the object.
   function automatic void advance_object(longint dt);
      longint len, d, a, h, v;
      if (speed_sq() > longint'(speed_limit * speed_limit)) begin
         len = longint'(int_sqrt(speed_sq()));
         for (int i = 0; i < 3; i++) obj_vel[i] = int'((longint'(obj_vel[i]) * speed_limit) / len);
      end
      for (int i = 0; i < 3; i++) begin
         d = (longint'(obj_vel[i]) * dt) >>> 16;
         obj_pos[i] = obj_pos[i] + d[31:0];
      end
      if (gravity_on != 0) obj_pos[1] = obj_pos[1] - gravity_amount[31:0];
      if (speed_sq() > (64'h1 << 32)) begin
         a = atan2_deg(obj_vel[0], obj_vel[2]) - 90 * 65536;
         h = (a + 256) >>> 9;
         if (h > 11520) h = 11520;
         if (h < -34560) h = -34560;
         obj_yaw = h[16:0];
      end
      for (int i = 0; i < 3; i++) begin
         v = (longint'(obj_vel[i]) * friction) >>> 16;
         if (v > 64'sh7FFFFFFF) v = 64'sh7FFFFFFF;
         if (v < -64'sh80000000) v = -64'sh80000000;
         obj_vel[i] = int'(v);
      end
   endfunction

   function automatic void predict_object(logic [1:0] cmd, logic [15:0] dt,
                                          logic [31:0] x, logic [31:0] y, logic [31:0] z);
      object_state_t s;
      case (cmd)
         CMD_STEP:     advance_object(longint'(dt));
         CMD_LOAD_VEL: begin
            obj_vel[0] = x; obj_vel[1] = y; obj_vel[2] = z;
         end
         CMD_LOAD_POS: begin
            obj_pos[0] = x; obj_pos[1] = y; obj_pos[2] = z;
         end
         default: ;
      endcase
      s.pos_x = obj_pos[0]; s.pos_y = obj_pos[1]; s.pos_z = obj_pos[2];
      s.vel_x = obj_vel[0]; s.vel_y = obj_vel[1]; s.vel_z = obj_vel[2];
      s.heading = obj_yaw;
      expected_states.push_back(s);
   endfunction

   // Send one request beat; the predictor runs when the beat is accepted.
   task automatic send_item(logic [1:0] cmd, logic [15:0] dt,
                            logic [31:0] x, logic [31:0] y, logic [31:0] z);
      if (!quiet && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cmd <= cmd; req_dt <= dt;
      req_value_x <= x; req_value_y <= y; req_value_z <= z;
      do @(posedge clock); while (req_stall);
      predict_object(cmd, dt, x, y, z);
      beats_sent++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (expected_states.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   // Register writes happen only with the unit drained.
   task automatic write_reg(logic [1:0] index, logic [31:0] data);
      drain();
      csr_valid <= 1'b1; csr_index <= index; csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (index)
         CSR_MAX_SPEED:    speed_limit = longint'(data[30:0]);
         CSR_USE_GRAVITY:  gravity_on = longint'(data[0]);
         CSR_GRAVITY_STEP: gravity_amount = longint'(data[30:0]);
         CSR_FRICTION:     friction = longint'(data[16:0]);
         default: ;
      endcase
   endtask

   // Velocity components of mixed magnitudes so both sides of the limit get hit.
   function automatic logic [31:0] rand_component();
      logic signed [31:0] r;
      r = $urandom;
      case ($urandom_range(4))
         0: return r;
         1: return r >>> $urandom_range(8, 26);
         2: return r >>> 28;
         3: return 32'd0;
         default: return r >>> 12;
      endcase
   endfunction

   task automatic send_random(int count, int step_pct);
      logic [1:0] cmd;
      int pick;
      repeat (count) begin
         pick = $urandom_range(99);
         if (pick < step_pct) cmd = CMD_STEP;
         else if (pick < step_pct + (99 - step_pct) / 2) cmd = CMD_LOAD_VEL;
         else if (pick < 98) cmd = CMD_LOAD_POS;
         else cmd = CMD_UNUSED;
         if (cmd == CMD_LOAD_POS)
            send_item(cmd, 16'($urandom), $urandom, $urandom, $urandom);
         else
            send_item(cmd, 16'($urandom), rand_component(), rand_component(),
                      rand_component());
      end
   endtask

   // Response side: random stall and in-order comparison.
   always @(posedge clock) begin
      object_state_t got, want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            got = '{rsp_pos_x, rsp_pos_y, rsp_pos_z, rsp_vel_x, rsp_vel_y, rsp_vel_z,
                    rsp_heading};
            if (expected_states.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected result beat: %p", got);
            end else begin
               want = expected_states.pop_front();
               if (got !== want) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("result %0d mismatch:\n  expected %p\n  actual   %p",
                              results_seen, want, got);
               end
            end
         end
      end
   end

   task automatic test_loads_and_extremes();
      send_item(CMD_LOAD_POS, 16'hFFFF, 32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF);
      send_item(CMD_LOAD_VEL, 16'hFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000);
      send_item(CMD_UNUSED, 16'h1234, 32'h5555AAAA, 32'hAAAA5555, 32'h0);
      // Clamp of a huge velocity, full and zero dt.
      send_item(CMD_STEP, 16'hFFFF, 0, 0, 0);
      send_item(CMD_STEP, 16'h0000, 0, 0, 0);
      // Zero horizontal velocity with speed above 1.0.
      send_item(CMD_LOAD_VEL, 0, 0, 32'h0003_0000, 0);
      send_item(CMD_STEP, 16'h8000, 0, 0, 0);
      // Three heading quadrants, and a speed just at 1.0 that leaves heading alone.
      send_item(CMD_LOAD_VEL, 0, 32'hFFFE_0000, 0, 32'h0002_0000);
      send_item(CMD_STEP, 16'h4000, 0, 0, 0);
      send_item(CMD_LOAD_VEL, 0, 32'hFFFE_0000, 0, 32'hFFFD_0000);
      send_item(CMD_STEP, 16'h4000, 0, 0, 0);
      send_item(CMD_LOAD_VEL, 0, 32'h0002_0000, 0, 32'hFFFF_0000);
      send_item(CMD_STEP, 16'h4000, 0, 0, 0);
      send_item(CMD_LOAD_VEL, 0, 32'h0001_0000, 0, 0);
      send_item(CMD_STEP, 16'h0001, 0, 0, 0);
   endtask

   task automatic test_gravity_and_friction();
      write_reg(CSR_USE_GRAVITY, 32'd1);
      write_reg(CSR_GRAVITY_STEP, 32'h7FFF_FFFF);
      write_reg(CSR_FRICTION, 32'd0);
      send_item(CMD_LOAD_VEL, 0, 32'h0004_0000, 32'h0001_0000, 32'h0002_0000);
      send_item(CMD_STEP, 16'hFFFF, 0, 0, 0);
      send_item(CMD_STEP, 16'hFFFF, 0, 0, 0);
      // Friction factor above 1.0 saturates the velocity.
      write_reg(CSR_MAX_SPEED, 32'h7FFF_FFFF);
      write_reg(CSR_FRICTION, 32'h1_FFFF);
      send_item(CMD_LOAD_VEL, 0, 32'h7000_0000, 32'h9000_0000, 32'h0000_0100);
      send_item(CMD_STEP, 16'h0100, 0, 0, 0);
      send_item(CMD_STEP, 16'h0100, 0, 0, 0);
   endtask

   task automatic test_limit_extremes();
      write_reg(CSR_FRICTION, 32'd65536);
      write_reg(CSR_USE_GRAVITY, 32'd0);
      write_reg(CSR_MAX_SPEED, 32'd0);
      send_item(CMD_LOAD_VEL, 0, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0003);
      send_item(CMD_STEP, 16'hFFFF, 0, 0, 0);
   endtask

   // Random phases under several register settings, reset values included.
   task automatic test_random_settings();
      write_reg(CSR_MAX_SPEED, 32'd655360);
      write_reg(CSR_GRAVITY_STEP, 32'd0);
      write_reg(CSR_FRICTION, 32'd65536);
      send_random(300, 60);
      for (int phase = 0; phase < 4; phase++) begin
         write_reg(CSR_MAX_SPEED, phase == 3 ? 32'h7FFF_FFFF : $urandom_range(1 << 22));
         write_reg(CSR_USE_GRAVITY, $urandom);
         write_reg(CSR_GRAVITY_STEP, phase == 1 ? $urandom : $urandom_range(1 << 18));
         write_reg(CSR_FRICTION, $urandom_range(40000, 65536));
         send_random(300, 60);
      end
      // A stretch with no idling on either side.
      quiet = 1'b1;
      send_random(250, 60);
      drain();
      quiet = 1'b0;
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      speed_limit = 655360; gravity_on = 0; gravity_amount = 0; friction = 65536;
      for (int i = 0; i < 3; i++) begin
         obj_pos[i] = '0; obj_vel[i] = 0;
      end
      obj_yaw = '0;
      @(posedge clock);
      test_loads_and_extremes();
      test_gravity_and_friction();
      test_limit_extremes();
      test_random_settings();
      drain();
      $display("Sent %0d request beats through directed and random register settings;",
               beats_sent);
      $display("checked %0d result beats, %0d mismatches.", results_seen, mismatches);
      if (mismatches == 0)
         $display("kinematic_object_step_unit regression: pass");
      else
         $display("kinematic_object_step_unit regression: fail");
      $finish;
   end

   initial begin
      #50ms;
      $display("Timed out with %0d results still expected.", expected_states.size());
      $display("kinematic_object_step_unit regression: fail");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/kos_pkg.sv
rtl/kinematic_object_step_unit.sv
rtl/kos_checker.sv
tb/kinematic_object_step_unit_tb.sv
